// ----- hdl/psk_pkg.sv -----
`default_nettype none

package psk_pkg;

	localparam int DEPTH      = 1024;
	localparam int MAX_SELECT = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int SEL_W      = 7;
	localparam int RANK_W     = 6;

	localparam logic [SEL_W-1:0] SEL_RESET = SEL_W'(8);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_HEAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} psk_state_t;

	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_HEAD,
		TAG_CMP
	} psk_tag_t;

	typedef struct packed {
		logic load_en;
		logic head;
		logic scan;
		logic emit;
		logic finish;
	} psk_cmd_t;

	typedef struct packed {
		logic close_go;
		logic scan_end;
		logic out_free;
		logic pass_last;
		logic swap;
	} psk_stat_t;

endpackage

`default_nettype wire

// ----- hdl/psk_ram.sv -----
`default_nettype none

module psk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/psk_ctrl.sv -----
`default_nettype none

module psk_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psk_pkg::psk_stat_t stat,
	output psk_pkg::psk_cmd_t       cmd
);

	import psk_pkg::*;

	psk_state_t state_q;
	psk_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (stat.close_go) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.pass_last ? ST_LOAD : ST_HEAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load_en = 1'b1;
			end
			ST_HEAD: begin
				cmd.head = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_EMIT: begin
				cmd.emit   = stat.out_free;
				cmd.finish = stat.out_free & stat.pass_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/psk_dpath.sv -----
`default_nettype none

module psk_dpath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire psk_pkg::psk_cmd_t                     cmd,
	output psk_pkg::psk_stat_t                         stat,
	input  wire logic                                  cfg_we,
	input  wire logic        [psk_pkg::SEL_W-1:0]      cfg_wdata,
	input  wire logic                                  in_valid,
	input  wire logic signed [psk_pkg::DATA_W-1:0]     energy_value,
	input  wire logic        [psk_pkg::DATA_W-1:0]     companion_value,
	input  wire logic                                  last_item,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic signed      [psk_pkg::DATA_W-1:0]     out_energy,
	output logic             [psk_pkg::DATA_W-1:0]     out_companion,
	output logic             [psk_pkg::RANK_W-1:0]     rank,
	output logic                                       out_last,
	output logic                                       overflowed
);

	import psk_pkg::*;

	logic [SEL_W-1:0]  sel_q;
	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [CNT_W-1:0]  n_q;
	logic [SEL_W-1:0]  k_q;
	logic [SEL_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	psk_tag_t          tag_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] held_key_q;
	logic [DATA_W-1:0] held_pay_q;
	logic              out_valid_q;

	logic              accept;
	logic              has_room;
	logic [CNT_W-1:0]  n_new;
	logic [SEL_W-1:0]  sel_cap;
	logic [SEL_W-1:0]  k_new;
	logic [SEL_W-1:0]  i_next;
	logic              scan_rd;
	logic              swap;
	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] wkey;
	logic [DATA_W-1:0] wpay;
	logic [DATA_W-1:0] rd_key;
	logic [DATA_W-1:0] rd_pay;

	assign accept   = in_valid & cmd.load_en;
	assign has_room = (count_q < CNT_W'(DEPTH));
	assign n_new    = has_room ? count_q + CNT_W'(1) : count_q;
	assign sel_cap  = (sel_q > SEL_W'(MAX_SELECT)) ? SEL_W'(MAX_SELECT) : sel_q;
	assign k_new    = (CNT_W'(sel_cap) > n_new) ? SEL_W'(n_new) : sel_cap;
	assign i_next   = i_q + SEL_W'(1);
	assign scan_rd  = cmd.scan & (j_q < n_q);
	assign out_free = ~out_valid_q | ~out_stall;

	// The running minimum for position i lives in the held registers; a smaller
	// key read at j trades places with it, so the old held pair is written to j.
	assign swap = (tag_s1 == TAG_CMP) && ($signed(held_key_q) > $signed(rd_key));

	assign ram_we = (accept & has_room) | swap;
	assign waddr  = swap ? addr_s1 : count_q[ADDR_W-1:0];
	assign wkey   = swap ? held_key_q : energy_value;
	assign wpay   = swap ? held_pay_q : companion_value;
	assign ram_re = cmd.head | scan_rd;
	assign raddr  = cmd.head ? ADDR_W'(i_q) : j_q[ADDR_W-1:0];

	psk_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wkey),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_key)
	);

	psk_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_pay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wpay),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_pay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= SEL_RESET;
			count_q     <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			tag_s1      <= TAG_NONE;
			addr_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sel_q <= cfg_wdata;
			end

			if (accept) begin
				if (last_item && k_new == '0) begin
					count_q <= '0;
					drop_q  <= 1'b0;
				end else if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
				if (last_item) begin
					n_q <= n_new;
					k_q <= k_new;
					i_q <= '0;
				end
			end else if (cmd.finish) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end

			if (cmd.head) begin
				j_q <= CNT_W'(i_q) + CNT_W'(1);
			end else if (scan_rd) begin
				j_q <= j_q + CNT_W'(1);
			end

			if (cmd.head) begin
				tag_s1 <= TAG_HEAD;
			end else if (scan_rd) begin
				tag_s1 <= TAG_CMP;
			end else begin
				tag_s1 <= TAG_NONE;
			end
			addr_s1 <= j_q[ADDR_W-1:0];

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				i_q         <= i_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1 == TAG_HEAD || swap) begin
			held_key_q <= rd_key;
			held_pay_q <= rd_pay;
		end
		if (cmd.emit) begin
			out_energy    <= $signed(held_key_q);
			out_companion <= held_pay_q;
			rank          <= i_q[RANK_W-1:0];
			out_last      <= (i_next == k_q);
			overflowed    <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

	// The scan stops issuing reads once the last index has been requested.
	assign stat.close_go  = accept & last_item & (k_new != '0);
	assign stat.scan_end  = ({1'b0, j_q} + (CNT_W + 1)'(1)) >= {1'b0, n_q};
	assign stat.out_free  = out_free;
	assign stat.pass_last = (i_next == k_q);
	assign stat.swap      = swap;

endmodule

`default_nettype wire

// ----- hdl/partial_selection_sort_top_k.sv -----
`default_nettype none

// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+-----------------------------------------
// config   | in        | cfg_we               | cfg_wdata (select_count)
// input    | in        | in_valid / in_stall  | energy_value, companion_value, last_item
// result   | out       | out_valid / out_stall| out_energy, out_companion, rank,
//          |           |                      | out_last, overflowed
//
// Loading accepts one input word per cycle while in_stall is low. After the
// closing word, each of the k selection passes reads position i, scans the
// stored positions after it, drains the last read and then emits the result
// once the result register is free; each memory has a single read port.
// Reset leaves the memories as they are and clears only counts and control.
// Input is stalled for the whole sort; a stalled result holds the next pass.

module partial_selection_sort_top_k (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic        [psk_pkg::SEL_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [psk_pkg::DATA_W-1:0] energy_value,
	input  wire logic        [psk_pkg::DATA_W-1:0] companion_value,
	input  wire logic                              last_item,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [psk_pkg::DATA_W-1:0] out_energy,
	output logic             [psk_pkg::DATA_W-1:0] out_companion,
	output logic             [psk_pkg::RANK_W-1:0] rank,
	output logic                                   out_last,
	output logic                                   overflowed
);

	import psk_pkg::*;

	psk_cmd_t  cmd;
	psk_stat_t stat;

	psk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	psk_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.energy_value    (energy_value),
		.companion_value (companion_value),
		.last_item       (last_item),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_energy      (out_energy),
		.out_companion   (out_companion),
		.rank            (rank),
		.out_last        (out_last),
		.overflowed      (overflowed)
	);

	assign in_stall = ~cmd.load_en;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded while the result register was occupied");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_last) |=>
			(!out_valid || rank == RANK_W'($past(rank) + RANK_W'(1))))
		else $error("results left out of rank order");

	a_swap_in_sort: assert property (@(posedge clk) disable iff (!arst_n)
		stat.swap |-> in_stall)
		else $error("memory exchange while input words were being taken");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import psk_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int TAIL_CYCLES   = 200;
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASE_WORDS   = 34;

	typedef struct {
		logic signed [DATA_W-1:0] energy;
		logic        [DATA_W-1:0] companion;
		logic                     last;
		logic                     drain_first;
	} energy_word_t;

	typedef struct {
		logic signed [DATA_W-1:0] energy;
		logic        [DATA_W-1:0] companion;
		logic        [RANK_W-1:0] rank;
		logic                     last;
		logic                     ovf;
	} ranked_pair_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_BURST,
		STALL_HEAVY
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SEL_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] energy_value = '0;
	logic [DATA_W-1:0] companion_value = '0;
	logic last_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] out_energy;
	logic [DATA_W-1:0] out_companion;
	logic [RANK_W-1:0] rank;
	logic out_last;
	logic overflowed;

	// Shadow of the block: stored pairs, fill level, drop flag and select count.
	logic signed [DATA_W-1:0] key_mem [DEPTH];
	logic        [DATA_W-1:0] pay_mem [DEPTH];
	int fill = 0;
	logic dropped = 1'b0;
	logic [SEL_W-1:0] sel_limit = SEL_RESET;

	energy_word_t pending_words[$];
	ranked_pair_t ranked_q[$];
	energy_word_t cur_word;

	int fail_count = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int stall_run = 0;

	partial_selection_sort_top_k DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.energy_value(energy_value),
		.companion_value(companion_value),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_energy(out_energy),
		.out_companion(out_companion),
		.rank(rank),
		.out_last(out_last),
		.overflowed(overflowed)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stores one word; a closing word runs the partial sort and queues the
	// smallest k pairs in position order.
	function automatic void absorb_word(energy_word_t w);
		int n;
		int k;
		logic signed [DATA_W-1:0] tk;
		logic [DATA_W-1:0] tp;
		ranked_pair_t r;
		if (fill < DEPTH) begin
			key_mem[fill] = w.energy;
			pay_mem[fill] = w.companion;
			fill++;
		end else begin
			dropped = 1'b1;
		end
		if (!w.last)
			return;
		n = fill;
		k = (int'(sel_limit) > MAX_SELECT) ? MAX_SELECT : int'(sel_limit);
		if (k > n)
			k = n;
		for (int i = 0; i < k; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (key_mem[i] > key_mem[j]) begin
					tk = key_mem[i];
					key_mem[i] = key_mem[j];
					key_mem[j] = tk;
					tp = pay_mem[i];
					pay_mem[i] = pay_mem[j];
					pay_mem[j] = tp;
				end
			end
		end
		for (int i = 0; i < k; i++) begin
			r.energy = key_mem[i];
			r.companion = pay_mem[i];
			r.rank = RANK_W'(i);
			r.last = (i == k - 1);
			r.ovf = dropped;
			ranked_q = {ranked_q, r};
		end
		fill = 0;
		dropped = 1'b0;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_energy();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return DATA_W'(int'($urandom_range(0, 6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_companion();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_word(input logic signed [DATA_W-1:0] e, input logic [DATA_W-1:0] c,
			input logic l, input logic drain);
		energy_word_t w;
		w.energy = e;
		w.companion = c;
		w.last = l;
		w.drain_first = drain;
		pending_words = {pending_words, w};
	endtask

	task automatic queue_set(input int n, input logic drain);
		for (int i = 0; i < n; i++)
			push_word(rand_energy(), rand_companion(), i == n - 1, drain && i == 0);
	endtask

	// Waits until nothing is in flight, then lets the block finish any pass.
	task automatic settle();
		while (pending_words.size() != 0 || in_valid || ranked_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_select(input int v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= SEL_W'(v);
		sel_limit = SEL_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : word_driver
		logic next_valid;
		energy_word_t w;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_word(cur_word);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].drain_first && ranked_q.size() != 0)) begin
					w = pending_words.pop_front();
					cur_word = w;
					energy_value <= w.energy;
					companion_value <= w.companion;
					last_item <= w.last;
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
		in_valid <= next_valid;
	end

	always @(posedge clk) begin : result_check
		ranked_pair_t want;
		logic next_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (ranked_q.size() == 0) begin
				$error("result with none expected: out_energy %0d rank %0d", out_energy, rank);
				fail_count++;
			end else begin
				want = ranked_q.pop_front();
				if (out_energy !== want.energy) begin
					$error("out_energy: expected %0d, got %0d", want.energy, out_energy);
					fail_count++;
				end
				if (out_companion !== want.companion) begin
					$error("out_companion: expected %h, got %h", want.companion, out_companion);
					fail_count++;
				end
				if (rank !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, rank);
					fail_count++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %b, got %b", want.last, out_last);
					fail_count++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed: expected %b, got %b", want.ovf, overflowed);
					fail_count++;
				end
			end
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: next_stall = 1'b0;
			STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
			STALL_BURST: begin
				if (stall_run > 0) begin
					stall_run--;
					next_stall = 1'b1;
				end else begin
					next_stall = 1'b0;
					if ($urandom_range(0, 7) == 0)
						stall_run = $urandom_range(1, 30);
				end
			end
			default: next_stall = ($urandom_range(0, 3) != 0);
		endcase
		out_stall <= next_stall;
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [DATA_W-1:0] dir_keys [10];
		logic [DATA_W-1:0] dir_pays [10];
		int phase_sel [8];
		int sel;
		int budget;
		int n;

		dir_keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345,
			32'hFFFF_F000};
		dir_pays = '{32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF,
			32'hFFFF_0000, 32'h1234_5678};
		phase_sel = '{1, 64, 0, 127, 65, -1, -1, 8};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset select count of 8: a one-word set, then ten words that must be cut to eight.
		push_word(32'sh8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
		for (int i = 0; i < 10; i++)
			push_word(dir_keys[i], dir_pays[i], i == 9, 1'b0);
		write_select(0);
		queue_set(3, 1'b0);
		write_select(127);
		queue_set(5, 1'b0);

		for (int p = 0; p < 8; p++) begin
			sel = (phase_sel[p] < 0) ? $urandom_range(2, 63) : phase_sel[p];
			write_select(sel);
			// The second set holds its first word until every result of the first is back.
			if (sel == 127) begin
				queue_set(12, 1'b0);
				queue_set(4, 1'b1);
			end
			budget = PHASE_WORDS;
			while (budget > 0) begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 12);
				queue_set(n, $urandom_range(0, 7) == 0);
				budget -= n;
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ranked_q.size() != 0) begin
			$error("%0d expected results never arrived", ranked_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
